>>> hw/rtl/primitive_assembler_macros.svh
// assertion macros for the primitive assembler checker
// no dependencies; included by files that hold concurrent assertions
`ifndef PRIMITIVE_ASSEMBLER_MACROS_SVH
`define PRIMITIVE_ASSEMBLER_MACROS_SVH

// clocked assertion, disabled while reset is high
`define PA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define PA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/pa_pkg.sv
// shared types and constants of the primitive assembler
// no dependencies; imported by every module of the block
package pa_pkg;

   localparam int FIELD_BITS = 32;
   localparam int INDEX_BITS = 32;
   localparam int MODE_BITS  = 4;
   localparam int COUNT_BITS = 3;

   localparam logic [MODE_BITS-1:0] MODE_POINTS     = 4'd0;
   localparam logic [MODE_BITS-1:0] MODE_LINES      = 4'd1;
   localparam logic [MODE_BITS-1:0] MODE_LINE_STRIP = 4'd2;
   localparam logic [MODE_BITS-1:0] MODE_LINE_LOOP  = 4'd3;
   localparam logic [MODE_BITS-1:0] MODE_TRIANGLES  = 4'd4;
   localparam logic [MODE_BITS-1:0] MODE_TRI_STRIP  = 4'd5;
   localparam logic [MODE_BITS-1:0] MODE_TRI_FAN    = 4'd6;
   localparam logic [MODE_BITS-1:0] MODE_QUADS      = 4'd7;
   localparam logic [MODE_BITS-1:0] MODE_QUAD_STRIP = 4'd8;
   localparam logic [MODE_BITS-1:0] MODE_RESET      = MODE_TRIANGLES;

   localparam int CSR_ADDR_BITS = 3;
   localparam logic CSR_IDX_MODE = 1'b0;

   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [FIELD_BITS-1:0] corner_a;
      logic [FIELD_BITS-1:0] corner_b;
      logic [FIELD_BITS-1:0] corner_c;
      logic [FIELD_BITS-1:0] corner_d;
      logic [COUNT_BITS-1:0] corner_count;
      logic [FIELD_BITS-1:0] primitive_number;
      logic                  run_last;
   } rsp_item_type;

   // up to two results per input transfer
   typedef struct packed {
      logic         push0;
      logic         push1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage

>>> hw/rtl/pa_csr.sv
// apb-style configuration register file: holds the mode register
// depends on pa_pkg
module pa_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [pa_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready,
   output logic [pa_pkg::MODE_BITS-1:0] mode
);
   import pa_pkg::*;

   logic [MODE_BITS-1:0] mode_ff;
   logic [MODE_BITS-1:0] mode_in;
   logic                 write_hit;
   logic                 reg_idx;

   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1];
   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel && csr_penable && csr_pwrite && (reg_idx == CSR_IDX_MODE);
   assign mode_in    = write_hit ? csr_pwdata[MODE_BITS-1:0] : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == CSR_IDX_MODE) begin
         csr_prdata[MODE_BITS-1:0] = mode_ff;
      end
   end

   assign mode = mode_ff;

endmodule

>>> hw/rtl/pa_core.sv
// input register, section state and primitive grouping logic
// depends on pa_pkg; pushes finished primitives into the result queue
module pa_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [pa_pkg::MODE_BITS-1:0] mode,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [pa_pkg::FIELD_BITS-1:0] req_index_value,
   input  logic                         req_section_end,
   input  logic                         queue_room,
   output pa_pkg::push_type             push
);
   import pa_pkg::*;

   localparam logic [COUNT_BITS-1:0] CNT_POINT = 3'd1;
   localparam logic [COUNT_BITS-1:0] CNT_LINE  = 3'd2;
   localparam logic [COUNT_BITS-1:0] CNT_TRI   = 3'd3;
   localparam logic [COUNT_BITS-1:0] CNT_QUAD  = 3'd4;

   function automatic logic [FIELD_BITS-1:0] widen(input logic [INDEX_BITS-1:0] x);
      logic [FIELD_BITS-1:0] w;
      w = '0;
      w[INDEX_BITS-1:0] = x;
      return w;
   endfunction

   function automatic logic [FIELD_BITS-1:0] sat_inc(input logic [FIELD_BITS-1:0] x);
      return (x == '1) ? x : x + 1'b1;
   endfunction

   // input register
   logic                  in_valid_ff;
   logic [INDEX_BITS-1:0] in_index_ff;
   logic                  in_end_ff;
   logic                  fire;

   // section state; position kept as its phases mod 4 and mod 3 plus a count saturating at 3
   logic [INDEX_BITS-1:0] recent_ff [3];
   logic [INDEX_BITS-1:0] recent_in [3];
   logic [INDEX_BITS-1:0] first_ff, first_in;
   logic [1:0]            pos_mod4_ff, pos_mod4_in;
   logic [1:0]            pos_mod3_ff, pos_mod3_in;
   logic [1:0]            pos_cnt_ff, pos_cnt_in;
   logic [FIELD_BITS-1:0] prim_cnt_ff, prim_cnt_in;

   logic [INDEX_BITS-1:0] v;
   logic [INDEX_BITS-1:0] first;
   logic                  hit;
   logic                  close_loop;
   logic [FIELD_BITS-1:0] cnt_next;
   rsp_item_type          prim;
   rsp_item_type          closing;

   assign fire      = in_valid_ff && queue_room;
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_index_ff <= req_index_value[INDEX_BITS-1:0];
         in_end_ff   <= req_section_end;
      end
   end

   assign v     = in_index_ff;
   assign first = (pos_cnt_ff == 2'd0) ? v : first_ff;

   always_comb begin
      hit  = 1'b0;
      prim = '0;
      prim.primitive_number = prim_cnt_ff;
      case (mode)
         MODE_POINTS: begin
            hit = 1'b1;
            prim.corner_a = widen(v);
            prim.corner_count = CNT_POINT;
         end
         MODE_LINES: begin
            hit = pos_mod4_ff[0];
            prim.corner_a = widen(recent_ff[0]);
            prim.corner_b = widen(v);
            prim.corner_count = CNT_LINE;
         end
         MODE_LINE_STRIP, MODE_LINE_LOOP: begin
            hit = (pos_cnt_ff != 2'd0);
            prim.corner_a = widen(recent_ff[0]);
            prim.corner_b = widen(v);
            prim.corner_count = CNT_LINE;
         end
         MODE_TRIANGLES: begin
            hit = (pos_mod3_ff == 2'd2);
            prim.corner_a = widen(recent_ff[1]);
            prim.corner_b = widen(recent_ff[0]);
            prim.corner_c = widen(v);
            prim.corner_count = CNT_TRI;
         end
         MODE_TRI_STRIP: begin
            hit = (pos_cnt_ff >= 2'd2);
            // odd primitives swap their first two corners
            prim.corner_a = widen(pos_mod4_ff[0] ? recent_ff[0] : recent_ff[1]);
            prim.corner_b = widen(pos_mod4_ff[0] ? recent_ff[1] : recent_ff[0]);
            prim.corner_c = widen(v);
            prim.corner_count = CNT_TRI;
         end
         MODE_TRI_FAN: begin
            hit = (pos_cnt_ff >= 2'd2);
            prim.corner_a = widen(first);
            prim.corner_b = widen(recent_ff[0]);
            prim.corner_c = widen(v);
            prim.corner_count = CNT_TRI;
         end
         MODE_QUADS, MODE_QUAD_STRIP: begin
            hit = (mode == MODE_QUADS) ? (pos_mod4_ff == 2'd3)
                                       : ((pos_cnt_ff == 2'd3) && pos_mod4_ff[0]);
            prim.corner_a = widen(recent_ff[2]);
            prim.corner_b = widen(recent_ff[1]);
            prim.corner_c = widen(recent_ff[0]);
            prim.corner_d = widen(v);
            prim.corner_count = CNT_QUAD;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   assign cnt_next   = hit ? sat_inc(prim_cnt_ff) : prim_cnt_ff;
   assign close_loop = (mode == MODE_LINE_LOOP) && in_end_ff && (pos_cnt_ff != 2'd0);

   always_comb begin
      closing = '0;
      closing.corner_a         = widen(v);
      closing.corner_b         = widen(first);
      closing.corner_count     = CNT_LINE;
      closing.primitive_number = cnt_next;
      closing.run_last         = 1'b1;
   end

   always_comb begin
      push = '0;
      push.push0 = fire && (hit || close_loop);
      push.push1 = fire && hit && close_loop;
      push.item0 = hit ? prim : closing;
      push.item0.run_last = !(hit && close_loop);
      push.item1 = closing;
   end

   always_comb begin
      recent_in   = recent_ff;
      first_in    = first_ff;
      pos_mod4_in = pos_mod4_ff;
      pos_mod3_in = pos_mod3_ff;
      pos_cnt_in  = pos_cnt_ff;
      prim_cnt_in = prim_cnt_ff;
      if (fire) begin
         if (in_end_ff) begin
            recent_in   = '{default: '0};
            first_in    = '0;
            pos_mod4_in = '0;
            pos_mod3_in = '0;
            pos_cnt_in  = '0;
            prim_cnt_in = '0;
         end else begin
            recent_in[2] = recent_ff[1];
            recent_in[1] = recent_ff[0];
            recent_in[0] = v;
            first_in     = first;
            pos_mod4_in  = pos_mod4_ff + 2'd1;
            pos_mod3_in  = (pos_mod3_ff == 2'd2) ? 2'd0 : pos_mod3_ff + 2'd1;
            pos_cnt_in   = (pos_cnt_ff == 2'd3) ? 2'd3 : pos_cnt_ff + 2'd1;
            prim_cnt_in  = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff   <= '{default: '0};
         first_ff    <= '0;
         pos_mod4_ff <= '0;
         pos_mod3_ff <= '0;
         pos_cnt_ff  <= '0;
         prim_cnt_ff <= '0;
      end else begin
         recent_ff   <= recent_in;
         first_ff    <= first_in;
         pos_mod4_ff <= pos_mod4_in;
         pos_mod3_ff <= pos_mod3_in;
         pos_cnt_ff  <= pos_cnt_in;
         prim_cnt_ff <= prim_cnt_in;
      end
   end

endmodule

>>> hw/rtl/pa_rsp_fifo.sv
// result queue: takes up to two primitives per cycle, hands out one per transfer
// depends on pa_pkg
module pa_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  pa_pkg::push_type     push,
   output logic                 queue_room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pa_pkg::rsp_item_type rsp_item
);
   import pa_pkg::*;

   rsp_item_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic [FIFO_PTR_BITS-1:0] wr_ptr_1;
   logic                     pop;
   logic [FIFO_CNT_BITS-1:0] n_push;

   assign pop        = rsp_valid && rsp_ready;
   assign wr_ptr_1   = wr_ptr_ff + 1'b1;
   assign n_push     = FIFO_CNT_BITS'(push.push0) + FIFO_CNT_BITS'(push.push1);
   assign wr_ptr_in  = wr_ptr_ff + n_push[FIFO_PTR_BITS-1:0];
   assign rd_ptr_in  = rd_ptr_ff + FIFO_PTR_BITS'(pop);
   assign count_in   = count_ff + n_push - FIFO_CNT_BITS'(pop);
   // room for a worst-case pair of results
   assign queue_room = (count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.push1) begin
         mem_ff[wr_ptr_1] <= push.item1;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = mem_ff[rd_ptr_ff];

endmodule

>>> hw/rtl/primitive_assembler.sv
// top level of the primitive assembler: config port, grouping core, result queue
// depends on pa_pkg, pa_csr, pa_core and pa_rsp_fifo

// Takes one vertex index per cycle and emits points, lines, triangles or quads
// as selected by the mode register; a new index is accepted every cycle as long as
// the four-entry result queue has room for two results. An index is registered
// before its results enter the queue. The result channel moves one primitive per
// cycle while rsp_ready is high, so a line loop's closing line adds one transfer
// at each section end. Write the mode register only while the block is idle.
module primitive_assembler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pa_pkg::FIELD_BITS-1:0]     req_index_value,
   input  logic                              req_section_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pa_pkg::FIELD_BITS-1:0]     rsp_corner_a,
   output logic [pa_pkg::FIELD_BITS-1:0]     rsp_corner_b,
   output logic [pa_pkg::FIELD_BITS-1:0]     rsp_corner_c,
   output logic [pa_pkg::FIELD_BITS-1:0]     rsp_corner_d,
   output logic [pa_pkg::COUNT_BITS-1:0]     rsp_corner_count,
   output logic [pa_pkg::FIELD_BITS-1:0]     rsp_primitive_number,
   output logic                              rsp_run_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pa_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import pa_pkg::*;

   logic [MODE_BITS-1:0] mode;
   logic                 queue_room;
   push_type             push;
   rsp_item_type         rsp_item;

   pa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mode        (mode)
   );

   pa_core u_core (
      .clock           (clock),
      .reset           (reset),
      .mode            (mode),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_index_value (req_index_value),
      .req_section_end (req_section_end),
      .queue_room      (queue_room),
      .push            (push)
   );

   pa_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .queue_room (queue_room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

   assign rsp_corner_a         = rsp_item.corner_a;
   assign rsp_corner_b         = rsp_item.corner_b;
   assign rsp_corner_c         = rsp_item.corner_c;
   assign rsp_corner_d         = rsp_item.corner_d;
   assign rsp_corner_count     = rsp_item.corner_count;
   assign rsp_primitive_number = rsp_item.primitive_number;
   assign rsp_run_last         = rsp_item.run_last;

endmodule

>>> hw/rtl/pa_checker.sv
// port-level checks of the primitive assembler, bound to the top level
// depends on pa_pkg and primitive_assembler_macros.svh
`include "primitive_assembler_macros.svh"

module pa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [pa_pkg::FIELD_BITS-1:0]    rsp_corner_a,
   input logic [pa_pkg::FIELD_BITS-1:0]    rsp_corner_b,
   input logic [pa_pkg::FIELD_BITS-1:0]    rsp_corner_d,
   input logic [pa_pkg::COUNT_BITS-1:0]    rsp_corner_count,
   input logic                             rsp_run_last,
   input logic                             csr_psel,
   input logic                             csr_penable,
   input logic                             csr_pwrite,
   input logic                             csr_pready,
   input logic [pa_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [31:0]                      csr_pwdata,
   input logic [31:0]                      csr_prdata
);
   import pa_pkg::*;

   logic mode_write;

   assign mode_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_ADDR_BITS-1] == CSR_IDX_MODE);

   // a stalled result keeps its payload
   `PA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_corner_a) && $stable(rsp_corner_count) && $stable(rsp_run_last), "result changed while stalled")

   // queue is empty right after reset
   `PA_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   `PA_ASSERT(a_count_range, clock, reset, rsp_valid |-> (rsp_corner_count == 3'd1 || rsp_corner_count == 3'd2 || rsp_corner_count == 3'd3 || rsp_corner_count == 3'd4), "corner count out of range")

   // unused corners b and d read as zero
   `PA_ASSERT(a_unused_zero, clock, reset, rsp_valid && rsp_corner_count != 3'd4 |-> rsp_corner_d == '0 && (rsp_corner_count != 3'd1 || rsp_corner_b == '0), "unused corner not zero")

   `PA_ASSERT(a_mode_readback, clock, reset, mode_write |=> csr_paddr[CSR_ADDR_BITS-1] != CSR_IDX_MODE || csr_prdata == {28'd0, $past(csr_pwdata[3:0])}, "mode readback mismatch")

endmodule

bind primitive_assembler pa_checker u_pa_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_corner_a     (rsp_corner_a),
   .rsp_corner_b     (rsp_corner_b),
   .rsp_corner_d     (rsp_corner_d),
   .rsp_corner_count (rsp_corner_count),
   .rsp_run_last     (rsp_run_last),
   .csr_psel         (csr_psel),
   .csr_penable      (csr_penable),
   .csr_pwrite       (csr_pwrite),
   .csr_pready       (csr_pready),
   .csr_paddr        (csr_paddr),
   .csr_pwdata       (csr_pwdata),
   .csr_prdata       (csr_prdata)
);

>>> verif/primitive_assembly_checker.sv
// checker for the primitive assembler: watches the index, result and config ports,
// predicts every primitive and compares it with what the block emits
// depends on pa_pkg
module primitive_assembly_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [pa_pkg::FIELD_BITS-1:0]    req_index_value,
   input  logic                             req_section_end,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [pa_pkg::FIELD_BITS-1:0]    rsp_corner_a,
   input  logic [pa_pkg::FIELD_BITS-1:0]    rsp_corner_b,
   input  logic [pa_pkg::FIELD_BITS-1:0]    rsp_corner_c,
   input  logic [pa_pkg::FIELD_BITS-1:0]    rsp_corner_d,
   input  logic [pa_pkg::COUNT_BITS-1:0]    rsp_corner_count,
   input  logic [pa_pkg::FIELD_BITS-1:0]    rsp_primitive_number,
   input  logic                             rsp_run_last,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pa_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   input  logic [31:0]                      csr_prdata,
   input  logic                             csr_pready,
   output int unsigned                      error_count,
   output int unsigned                      prims_outstanding,
   output int unsigned                      prims_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import pa_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] MODE_ADDR = CSR_ADDR_BITS'(CSR_IDX_MODE) << 2;
   localparam logic [FIELD_BITS-1:0] INDEX_MASK =
      FIELD_BITS'((64'd1 << INDEX_BITS) - 64'd1);

   logic [MODE_BITS-1:0]  mode_reg;
   logic [FIELD_BITS-1:0] recent_idx [3];
   logic [FIELD_BITS-1:0] first_idx;
   logic [FIELD_BITS-1:0] position;
   logic [FIELD_BITS-1:0] prim_count;
   rsp_item_type          pending_primitives [$];

   function automatic rsp_item_type make_prim(input logic [FIELD_BITS-1:0] a, b, c, d,
                                              input int corners);
      rsp_item_type item;
      item.corner_a         = a;
      item.corner_b         = b;
      item.corner_c         = c;
      item.corner_d         = d;
      item.corner_count     = COUNT_BITS'(corners);
      item.primitive_number = prim_count;
      item.run_last         = 1'b0;
      return item;
   endfunction

   task automatic assemble_index(input logic [FIELD_BITS-1:0] raw, input logic last);
      logic [FIELD_BITS-1:0] v, p, r0, r1, r2, first;
      rsp_item_type made [$];
      rsp_item_type item;
      v = raw & INDEX_MASK;
      p = position;
      r0 = recent_idx[0];
      r1 = recent_idx[1];
      r2 = recent_idx[2];
      first = (p == 0) ? v : first_idx;
      case (mode_reg)
         MODE_POINTS: made = {made, make_prim(v, '0, '0, '0, 1)};
         MODE_LINES: if (p[0]) made = {made, make_prim(r0, v, '0, '0, 2)};
         MODE_LINE_STRIP, MODE_LINE_LOOP: begin
            if (p >= 1) made = {made, make_prim(r0, v, '0, '0, 2)};
         end
         MODE_TRIANGLES: if (p % 3 == 2) made = {made, make_prim(r1, r0, v, '0, 3)};
         MODE_TRI_STRIP: begin
            // odd strip triangles swap their first two corners
            if (p >= 2) begin
               if (p[0]) made = {made, make_prim(r0, r1, v, '0, 3)};
               else made = {made, make_prim(r1, r0, v, '0, 3)};
            end
         end
         MODE_TRI_FAN: if (p >= 2) made = {made, make_prim(first, r0, v, '0, 3)};
         MODE_QUADS: if (p[1:0] == 2'b11) made = {made, make_prim(r2, r1, r0, v, 4)};
         MODE_QUAD_STRIP: begin
            if (p >= 3 && p[0]) made = {made, make_prim(r2, r1, r0, v, 4)};
         end
         default: ;
      endcase
      if (made.size() > 0 && prim_count != '1) prim_count++;
      // closing line of a loop, numbered after the regular line
      if (mode_reg == MODE_LINE_LOOP && last && p >= 1) begin
         made = {made, make_prim(v, first, '0, '0, 2)};
         if (prim_count != '1) prim_count++;
      end
      foreach (made[i]) begin
         item = made[i];
         item.run_last = (i == made.size() - 1);
         pending_primitives = {pending_primitives, item};
      end
      if (last) begin
         recent_idx = '{default: '0};
         first_idx = '0;
         position = '0;
         prim_count = '0;
      end else begin
         recent_idx[2] = r1;
         recent_idx[1] = r0;
         recent_idx[0] = v;
         first_idx = first;
         // fold back keeping the phase modulo 2, 3 and 4
         position = (p == '1) ? FIELD_BITS'(4) : p + 1;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   task automatic compare_primitive();
      rsp_item_type want;
      if (pending_primitives.size() == 0) begin
         $error("unexpected result transfer: corners %0h %0h %0h %0h",
                rsp_corner_a, rsp_corner_b, rsp_corner_c, rsp_corner_d);
         error_count++;
      end else begin
         want = pending_primitives.pop_front();
         check_field("corner_a", want.corner_a, rsp_corner_a);
         check_field("corner_b", want.corner_b, rsp_corner_b);
         check_field("corner_c", want.corner_c, rsp_corner_c);
         check_field("corner_d", want.corner_d, rsp_corner_d);
         check_field("corner_count", 32'(want.corner_count), 32'(rsp_corner_count));
         check_field("primitive_number", want.primitive_number, rsp_primitive_number);
         check_field("run_last", 32'(want.run_last), 32'(rsp_run_last));
         prims_checked++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_reg = MODE_RESET;
         recent_idx = '{default: '0};
         first_idx = '0;
         position = '0;
         prim_count = '0;
         pending_primitives.delete();
         error_count = 0;
         prims_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) compare_primitive();
         if (req_valid && req_ready) assemble_index(req_index_value, req_section_end);
         if (csr_psel && csr_penable && csr_pready && csr_paddr == MODE_ADDR) begin
            if (csr_pwrite) begin
               mode_reg = csr_pwdata[MODE_BITS-1:0];
            end else if (csr_prdata[MODE_BITS-1:0] !== mode_reg) begin
               $error("mode readback: expected %0h, got %0h", mode_reg,
                      csr_prdata[MODE_BITS-1:0]);
               error_count++;
            end
         end
      end
      prims_outstanding = pending_primitives.size();
   end

endmodule

>>> verif/tb.sv
// testbench top for the primitive assembler: clock, reset, index stimulus,
// mode register writes and the verdict; depends on pa_pkg, primitive_assembler
// and primitive_assembly_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pa_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] MODE_ADDR = CSR_ADDR_BITS'(CSR_IDX_MODE) << 2;
   localparam logic [MODE_BITS-1:0] MODE_UNKNOWN_MAX = '1;
   localparam int INDEX_TARGET = 900;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FIELD_BITS-1:0]    req_index_value = '0;
   logic                     req_section_end = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [FIELD_BITS-1:0]    rsp_corner_a;
   logic [FIELD_BITS-1:0]    rsp_corner_b;
   logic [FIELD_BITS-1:0]    rsp_corner_c;
   logic [FIELD_BITS-1:0]    rsp_corner_d;
   logic [COUNT_BITS-1:0]    rsp_corner_count;
   logic [FIELD_BITS-1:0]    rsp_primitive_number;
   logic                     rsp_run_last;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0]              csr_pwdata = '0;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   int unsigned error_count;
   int unsigned prims_outstanding;
   int unsigned prims_checked;

   int burst_left = 0;
   int indices_sent = 0;
   int mode_writes = 0;
   int stall_style = 0;
   int stall_left = 0;

   primitive_assembler uut (.*);
   primitive_assembly_checker u_checker (.*);

   always #5 clock = ~clock;

   // receiver: stretches of full rate, random stalls, heavy stalls and a fixed beat
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left = $urandom_range(40, 300);
      end
      stall_left--;
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= stall_left[1];
      endcase
   end

   task automatic send_index(input logic [FIELD_BITS-1:0] value, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_index_value <= value;
      req_section_end <= last;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      indices_sent++;
   endtask

   // stop sending and wait until every predicted primitive has come out
   task automatic settle(input int tail);
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (prims_outstanding != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic set_mode(input logic [MODE_BITS-1:0] m);
      settle(4);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= MODE_ADDR;
      // upper bits carry noise, only the low mode bits count
      csr_pwdata <= ($urandom() & ~((32'd1 << MODE_BITS) - 1)) | 32'(m);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // read it back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      mode_writes++;
   endtask

   function automatic logic [FIELD_BITS-1:0] random_index();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2, 3: return FIELD_BITS'($urandom_range(0, 255));
         default: return FIELD_BITS'($urandom());
      endcase
   endfunction

   function automatic int group_size(input logic [MODE_BITS-1:0] m);
      case (m)
         MODE_POINTS: return 1;
         MODE_LINES, MODE_LINE_STRIP, MODE_LINE_LOOP: return 2;
         MODE_QUADS, MODE_QUAD_STRIP: return 4;
         default: return 3;
      endcase
   endfunction

   // mostly whole primitives, with some short and ragged sections and a rare long one
   function automatic int section_length(input logic [MODE_BITS-1:0] m);
      int pick;
      pick = $urandom_range(0, 39);
      if (pick == 0) return $urandom_range(60, 120);
      if (pick < 7) return $urandom_range(1, group_size(m));
      if (pick < 13) return $urandom_range(1, 30);
      return group_size(m) * $urandom_range(1, 6);
   endfunction

   initial begin
      int counted;
      int phase;
      int sections;
      int len;
      logic open_end;
      logic [MODE_BITS-1:0] m;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // triangles out of reset, leftover indices dropped
      send_index('0, 1'b0);
      send_index('1, 1'b0);
      send_index(32'hAAAA_AAAA, 1'b0);
      send_index(32'h5555_5555, 1'b1);
      set_mode(MODE_POINTS);
      send_index('1, 1'b1);
      set_mode(MODE_LINES);
      send_index(32'd1, 1'b0);
      send_index(32'd2, 1'b1);
      // line strip switched to a fan in the middle of a section
      set_mode(MODE_LINE_STRIP);
      send_index(32'd3, 1'b0);
      send_index(32'd4, 1'b0);
      set_mode(MODE_TRI_FAN);
      send_index(32'd5, 1'b1);
      // loop with its closing line, then a loop too short for any line
      set_mode(MODE_LINE_LOOP);
      send_index(32'd7, 1'b0);
      send_index(32'd8, 1'b0);
      send_index(32'd9, 1'b1);
      send_index(32'd42, 1'b1);
      set_mode(MODE_TRI_STRIP);
      for (int i = 1; i <= 4; i++) send_index(FIELD_BITS'(i), i == 4);
      set_mode(MODE_QUADS);
      for (int i = 1; i <= 4; i++) send_index(FIELD_BITS'(i), i == 4);
      set_mode(MODE_QUAD_STRIP);
      for (int i = 1; i <= 4; i++) send_index(FIELD_BITS'(i), i == 4);
      set_mode(MODE_UNKNOWN_MAX);
      send_index(32'd9, 1'b1);

      // random phases: every register value first, then mostly the real modes
      counted = 0;
      phase = 0;
      while (counted < INDEX_TARGET) begin
         if (phase < 16) m = MODE_BITS'(phase);
         else if ($urandom_range(0, 9) == 0) m = MODE_BITS'($urandom_range(9, 15));
         else m = MODE_BITS'($urandom_range(0, 8));
         set_mode(m);
         sections = (m > MODE_QUAD_STRIP) ? 1 : $urandom_range(1, 6);
         for (int s = 0; s < sections; s++) begin
            len = section_length(m);
            // sometimes leave the section open across the next mode change
            open_end = (s == sections - 1) && ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) send_index(random_index(), i == len - 1 && !open_end);
            counted += len;
         end
         phase++;
      end

      settle(8);
      $display("primitive_assembler: %0d index transfers, %0d mode writes, %0d primitives checked",
               indices_sent, mode_writes, prims_checked);
      if (error_count == 0) begin
         $display("[primitive_assembler] OK");
      end else begin
         $display("[primitive_assembler] ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d primitives outstanding", prims_outstanding);
      $display("[primitive_assembler] ERROR");
      $finish;
   end

endmodule
